>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CFL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfl: same-cycle check failed");

// Next-cycle implication.
`define CFL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfl: next-cycle check failed");

`endif

>>> rtl/cfl_pkg.sv
package cfl_pkg;

    localparam int MAX_SEGMENTS   = 256;
    localparam int GLYPH_WORDS    = 1024;
    localparam int METRIC_ENTRIES = 1024;

    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
    localparam int GW_AW  = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
    localparam int MET_AW = (METRIC_ENTRIES > 1) ? $clog2(METRIC_ENTRIES) : 1;

    localparam int SLOT_W     = 10;
    localparam int CODE_W     = 16;
    localparam int SEGCNT_W   = 9;
    localparam int METCNT_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SUM_W      = 17;
    localparam int IDX_W      = 19;

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METRIC_COUNT  = 2'd1;

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_SEG    = 2'd1,
        K_GLYPH  = 2'd2,
        K_WIDTH  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   slot;
        logic [CODE_W-1:0]   code;
        logic [CODE_W-1:0]   start_code;
        logic signed [15:0]  id_delta;
        logic [15:0]         range_offset;
        logic [15:0]         word;
    } t_in;

    typedef struct packed {
        logic [15:0] glyph_id;
        logic [15:0] advance_width;
        logic        mapped;
        logic        bad_index;
    } t_out;

    typedef struct packed {
        logic [CODE_W-1:0] end_code;
        logic [CODE_W-1:0] start_code;
        logic [15:0]       id_delta;
        logic [15:0]       range_offset;
    } t_seg;

endpackage

>>> rtl/cfl_ram.sv
module cfl_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cmap_format4_glyph_lookup.sv
// Loads give no result. The scan reads one segment record a cycle, up to min(count,
// 256), and stops at the first with end >= code. That segment is unmapped if start >
// code, maps by id_delta if range offset is 0, else through a glyph index that is checked
// (bad index) before the glyph array is read; the width array is read last. No
// transfer is taken until the result is written; a stalled, full result register
// holds the lookup in its last state. Sync active-low reset: counts to 1, memories kept.
`include "assert_macros.svh"

module cmap_format4_glyph_lookup (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cfl_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cfl_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [cfl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cfl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import cfl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_SEG  = 8'b0000_0100,
        S_IDX  = 8'b0000_1000,
        S_GRD  = 8'b0001_0000,
        S_GWD  = 8'b0010_0000,
        S_WRD  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [SEGCNT_W-1:0]   r_seg_count;
    logic [METCNT_W-1:0]   r_metric_count;
    logic [CODE_W-1:0]     r_code, n_code;
    logic [SEG_CW-1:0]     r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [SEG_AW-1:0]     r_pidx, n_pidx;
    logic [SEG_AW-1:0]     r_hidx, n_hidx;
    t_seg                  r_seg, n_seg;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [GW_AW-1:0]      r_gidx, n_gidx;
    logic [15:0]           r_glyph, n_glyph;
    logic                  r_mapped, n_mapped;
    logic                  r_bad, n_bad;
    t_out                  r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  in_acc;
    logic                  seg_we, gw_we, wid_we;
    logic                  seg_re, gw_re, wid_re;
    t_seg                  seg_wdata, seg_rdata;
    logic [15:0]           gw_rdata, wid_rdata;
    logic [SEG_CW-1:0]     nseg;
    logic                  hit;
    logic [CODE_W-1:0]     diff;
    logic signed [IDX_W-1:0] gidx;
    logic                  gidx_bad;
    logic [METCNT_W-1:0]   mc_m1;
    logic [MET_AW-1:0]     lim;
    logic [MET_AW-1:0]     widx;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Load writes
    assign seg_we = in_acc && (i_in_data.kind == K_SEG)
                 && ({{(32-SLOT_W){1'b0}}, i_in_data.slot} < 32'(MAX_SEGMENTS));
    assign gw_we  = in_acc && (i_in_data.kind == K_GLYPH)
                 && ({{(32-SLOT_W){1'b0}}, i_in_data.slot} < 32'(GLYPH_WORDS));
    assign wid_we = in_acc && (i_in_data.kind == K_WIDTH)
                 && ({{(32-SLOT_W){1'b0}}, i_in_data.slot} < 32'(METRIC_ENTRIES));

    assign seg_wdata.end_code     = i_in_data.code;
    assign seg_wdata.start_code   = i_in_data.start_code;
    assign seg_wdata.id_delta     = i_in_data.id_delta;
    assign seg_wdata.range_offset = i_in_data.range_offset;

    assign nseg = (32'(r_seg_count) > 32'(MAX_SEGMENTS)) ? SEG_CW'(MAX_SEGMENTS)
                                                         : SEG_CW'(r_seg_count);

    assign seg_re = (r_state == S_SCAN) && (32'(r_idx) < 32'(nseg));
    assign gw_re  = (r_state == S_GRD);
    assign wid_re = (r_state == S_WRD);
    assign hit    = r_pend && (seg_rdata.end_code >= r_code);

    assign diff = r_code - r_seg.start_code;
    assign gidx = IDX_W'(r_sum) + IDX_W'(r_hidx) - IDX_W'(nseg);
    assign gidx_bad = gidx[IDX_W-1] || (gidx >= IDX_W'(GLYPH_WORDS));

    // Width index: min(glyph, metric_count - 1, METRIC_ENTRIES - 1)
    assign mc_m1 = (r_metric_count == '0) ? '0 : (r_metric_count - METCNT_W'(1));
    assign lim   = (32'(mc_m1) > 32'(METRIC_ENTRIES - 1)) ? MET_AW'(METRIC_ENTRIES - 1)
                                                          : MET_AW'(mc_m1);
    assign widx  = (32'(r_glyph) > 32'(lim)) ? lim : MET_AW'(r_glyph);

    cfl_ram #(.W($bits(t_seg)), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (SEG_AW'(i_in_data.slot)),
        .i_wdata (seg_wdata),
        .i_re    (seg_re),
        .i_raddr (r_idx[SEG_AW-1:0]),
        .o_rdata (seg_rdata)
    );

    cfl_ram #(.W(16), .DEPTH(GLYPH_WORDS)) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (gw_we),
        .i_waddr (GW_AW'(i_in_data.slot)),
        .i_wdata (i_in_data.word),
        .i_re    (gw_re),
        .i_raddr (r_gidx),
        .o_rdata (gw_rdata)
    );

    cfl_ram #(.W(16), .DEPTH(METRIC_ENTRIES)) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (wid_we),
        .i_waddr (MET_AW'(i_in_data.slot)),
        .i_wdata (i_in_data.word),
        .i_re    (wid_re),
        .i_raddr (widx),
        .o_rdata (wid_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_hidx      = r_hidx;
        n_seg       = r_seg;
        n_sum       = r_sum;
        n_gidx      = r_gidx;
        n_glyph     = r_glyph;
        n_mapped    = r_mapped;
        n_bad       = r_bad;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.kind == K_LOOKUP)) begin
                    n_code  = i_in_data.code;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_hidx  = r_pidx;
                    n_seg   = seg_rdata;
                    n_state = S_SEG;
                end else if (!r_pend && !seg_re) begin
                    n_glyph  = '0;
                    n_mapped = 1'b0;
                    n_bad    = 1'b0;
                    n_state  = S_WRD;
                end else begin
                    n_pidx = r_idx[SEG_AW-1:0];
                    n_pend = seg_re;
                    if (seg_re) begin
                        n_idx = r_idx + SEG_CW'(1);
                    end
                end
            end
            S_SEG: begin
                n_bad = 1'b0;
                if (r_seg.start_code > r_code) begin
                    n_glyph  = '0;
                    n_mapped = 1'b0;
                    n_state  = S_WRD;
                end else if (r_seg.range_offset == '0) begin
                    n_glyph  = r_code + r_seg.id_delta;
                    n_mapped = 1'b1;
                    n_state  = S_WRD;
                end else begin
                    n_sum    = SUM_W'(r_seg.range_offset[15:1]) + SUM_W'(diff);
                    n_mapped = 1'b1;
                    n_state  = S_IDX;
                end
            end
            S_IDX: begin
                n_gidx = gidx[GW_AW-1:0];
                if (gidx_bad) begin
                    n_glyph = '0;
                    n_bad   = 1'b1;
                    n_state = S_WRD;
                end else begin
                    n_state = S_GRD;
                end
            end
            S_GRD: begin
                n_state = S_GWD;
            end
            S_GWD: begin
                n_glyph = (gw_rdata != '0) ? (gw_rdata + r_seg.id_delta) : '0;
                n_state = S_WRD;
            end
            S_WRD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.glyph_id      = r_glyph;
                    n_out.advance_width = wid_rdata;
                    n_out.mapped        = r_mapped;
                    n_out.bad_index     = r_bad;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_pend         <= 1'b0;
            r_idx          <= '0;
            r_seg_count    <= SEGCNT_W'(1);
            r_metric_count <= METCNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_idx       <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SEGMENT_COUNT: r_seg_count    <= i_cfg_data[SEGCNT_W-1:0];
                    REG_METRIC_COUNT:  r_metric_count <= i_cfg_data[METCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_pidx   <= n_pidx;
        r_hidx   <= n_hidx;
        r_seg    <= n_seg;
        r_sum    <= n_sum;
        r_gidx   <= n_gidx;
        r_glyph  <= n_glyph;
        r_mapped <= n_mapped;
        r_bad    <= n_bad;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CFL_ASSERT_IMP(a_bad_is_mapped, r_out_valid && r_out.bad_index, r_out.mapped && (r_out.glyph_id == '0))
    `CFL_ASSERT_IMP(a_unmapped_zero, r_out_valid && !r_out.mapped, r_out.glyph_id == '0)
    `CFL_ASSERT_NXT(a_lookup_starts, in_acc && (i_in_data.kind == K_LOOKUP), r_state == S_SCAN)
    `CFL_ASSERT_IMP(a_scan_bound, r_state == S_SCAN, 32'(r_idx) <= 32'(nseg))
    `CFL_ASSERT_NXT(a_done_fills, (r_state == S_DONE) && !(r_out_valid && i_out_stall), o_out_valid && (r_state == S_IDLE))

endmodule
